/* hw/rtl/plti_pkg.sv */
// shared types and constants of the piecewise-linear table interpolator
package plti_pkg;

   // payload widths fixed by the interface
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   // request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // divider: quotient bits produced, bits retired per cycle, saturation point
   localparam int QUO_W       = 42;
   localparam int DIV_BITS    = 2;
   localparam int DIV_STEPS   = QUO_W / DIV_BITS;
   localparam int OFF_W       = QUO_W;
   localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(64'd1 << 40);

   // one table entry
   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } point_type;

endpackage

/* hw/rtl/plti_mem.sv */
// breakpoint table: one write port, one read port with registered read data
module plti_mem import plti_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  point_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output point_type         rd_data
);

   point_type mem [TABLE_DEPTH];
   point_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/plti_div.sv */
// unsigned 64 by 32 divider, two quotient bits per cycle, saturated quotient
module plti_div import plti_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [63:0]       dividend,
   input  logic [31:0]       divisor,
   output logic              done,
   output logic [QUO_W-2:0]  quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [31:0]      rem_ff, rem_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;

   // two restoring steps per cycle; remainder stays below the divisor unless the quotient overflows
   always_comb begin
      logic [32:0] trial;
      logic [31:0] rem_v;
      logic [QUO_W-1:0] low_v;
      logic [QUO_W-1:0] quo_v;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      rem_v   = rem_ff;
      low_v   = low_ff;
      quo_v   = quo_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_STEPS);
         // quotient at or above 2^42 only when the top bits reach the divisor
         ovf_in  = {10'd0, dividend[63:QUO_W]} >= divisor;
         rem_in  = {10'd0, dividend[63:QUO_W]};
         low_in  = dividend[QUO_W-1:0];
         quo_in  = '0;
      end else if (busy_ff) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            trial = {rem_v, low_v[QUO_W-1]};
            low_v = {low_v[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial = trial - {1'b0, divisor};
               quo_v = {quo_v[QUO_W-2:0], 1'b1};
            end else begin
               quo_v = {quo_v[QUO_W-2:0], 1'b0};
            end
            rem_v = trial[31:0];
         end
         rem_in = rem_v;
         low_in = low_v;
         quo_in = quo_v;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   // clamp at 2^40
   always_comb begin
      if (ovf_ff || (quo_ff > QUO_MAX)) begin
         quotient = QUO_MAX[QUO_W-2:0];
      end else begin
         quotient = quo_ff[QUO_W-2:0];
      end
   end

   assign done = done_ff;

endmodule

/* hw/rtl/piecewise_linear_table_interp.sv */
// piecewise-linear interpolation over a breakpoint table with binary search
// timing: a load request writes the table directly; a query outside the table answers after
//   the first point read, or the last point read too; one inside takes s search steps of one
//   table read each, at most ceil(log2(point_count - 1)), then the divider (two quotient
//   bits a cycle); a zero-length interval skips the divider
// throughput: one query at a time; the next request is taken once the result is out
// reset: point_count returns to 2, the table contents stay undefined until loaded
module piecewise_linear_table_interp import plti_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [INDEX_W-1:0]       req_point_index,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   input  logic signed [DATA_W-1:0] req_query_x,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_interp_value,
   output logic                     rsp_zero_interval,
   input  logic                     csr_wr_en,
   input  logic [COUNT_W-1:0]       csr_wr_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHK_LO = 4'd1;
   localparam logic [3:0] ST_CHK_HI = 4'd2;
   localparam logic [3:0] ST_SEARCH = 4'd3;
   localparam logic [3:0] ST_RD_LO  = 4'd4;
   localparam logic [3:0] ST_RD_HI  = 4'd5;
   localparam logic [3:0] ST_MAG    = 4'd6;
   localparam logic [3:0] ST_MUL    = 4'd7;
   localparam logic [3:0] ST_DIV_GO = 4'd8;
   localparam logic [3:0] ST_DIV_WT = 4'd9;
   localparam logic [3:0] ST_OFFS   = 4'd10;
   localparam logic [3:0] ST_SUM    = 4'd11;
   localparam logic [3:0] ST_FINISH = 4'd12;

   logic [3:0]               state_ff, state_in;
   logic [COUNT_W-1:0]       point_count_ff;
   logic signed [DATA_W-1:0] qx_ff, qx_in;
   logic [ADDR_W-1:0]        last_ff, last_in;
   logic [ADDR_W-1:0]        lo_ff, lo_in;
   logic [ADDR_W-1:0]        hi_ff, hi_in;
   logic [ADDR_W-1:0]        mid_ff, mid_in;
   logic signed [DATA_W-1:0] xl_ff, xl_in;
   logic signed [DATA_W-1:0] yl_ff, yl_in;
   logic signed [DATA_W:0]   len_ff, len_in;
   logic signed [DATA_W:0]   dx_ff, dx_in;
   logic signed [DATA_W:0]   dy_ff, dy_in;
   logic [DATA_W-1:0]        mlen_ff, mlen_in;
   logic [DATA_W-1:0]        mdx_ff, mdx_in;
   logic [DATA_W-1:0]        mdy_ff, mdy_in;
   logic                     neg_ff, neg_in;
   logic [2*DATA_W-1:0]      prod_ff, prod_in;
   logic signed [OFF_W-1:0]  off_ff, off_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     flag_ff, flag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_flag_ff, rsp_flag_in;

   logic              req_accept;
   logic [31:0]       load_index;
   logic [31:0]       count_eff;
   logic              mem_wr_en;
   point_type         mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   point_type         mem_rd_data;
   logic              div_start;
   logic              div_done;
   logic [QUO_W-2:0]  div_quotient;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= COUNT_W'(2);
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   // point count clamped to between 2 and the table size
   always_comb begin
      count_eff = 32'(point_count_ff);
      if (count_eff < 32'd2) begin
         count_eff = 32'd2;
      end else if (count_eff > 32'(TABLE_DEPTH)) begin
         count_eff = 32'(TABLE_DEPTH);
      end
   end

   // load requests write the table directly; out-of-range indexes are dropped
   assign load_index    = 32'(req_point_index);
   assign mem_wr_en     = req_accept && (req_op == OP_LOAD) &&
                          (load_index < 32'(TABLE_DEPTH));
   assign mem_wr_data.x = req_point_x;
   assign mem_wr_data.y = req_point_y;

   plti_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (load_index[ADDR_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign div_start = (state_ff == ST_DIV_GO);

   plti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (mlen_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer: table reads, search, then the interpolation datapath
   always_comb begin
      logic [ADDR_W:0]          sum_v;
      logic [ADDR_W-1:0]        lo_v;
      logic [ADDR_W-1:0]        hi_v;
      logic signed [OFF_W:0]    total_v;
      state_in     = state_ff;
      qx_in        = qx_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      len_in       = len_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      mlen_in      = mlen_ff;
      mdx_in       = mdx_ff;
      mdy_in       = mdy_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      off_in       = off_ff;
      res_in       = res_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      sum_v        = '0;
      lo_v         = lo_ff;
      hi_v         = hi_ff;
      total_v      = '0;
      case (state_ff)
         ST_IDLE: begin
            // a query starts by reading the first point
            if (req_accept && (req_op == OP_QUERY)) begin
               qx_in     = req_query_x;
               last_in   = ADDR_W'(count_eff - 32'd1);
               mem_rd_en = 1'b1;
               state_in  = ST_CHK_LO;
            end
         end
         ST_CHK_LO: begin
            // below the first x
            if (qx_ff < mem_rd_data.x) begin
               res_in   = mem_rd_data.y;
               flag_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = last_ff;
               state_in    = ST_CHK_HI;
            end
         end
         ST_CHK_HI: begin
            // above the last x, else open the search
            if (qx_ff > mem_rd_data.x) begin
               res_in   = mem_rd_data.y;
               flag_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               lo_in     = '0;
               hi_in     = last_ff;
               sum_v     = {1'b0, last_ff} + (ADDR_W+1)'(1);
               mid_in    = sum_v[ADDR_W:1];
               mem_rd_en = 1'b1;
               if (last_ff > ADDR_W'(1)) begin
                  mem_rd_addr = sum_v[ADDR_W:1];
                  state_in    = ST_SEARCH;
               end else begin
                  mem_rd_addr = '0;
                  state_in    = ST_RD_LO;
               end
            end
         end
         ST_SEARCH: begin
            // one bisection step per table read
            if (qx_ff < mem_rd_data.x) begin
               hi_v = mid_ff;
            end else begin
               lo_v = mid_ff;
            end
            lo_in     = lo_v;
            hi_in     = hi_v;
            sum_v     = {1'b0, hi_v} + {1'b0, lo_v};
            mid_in    = sum_v[ADDR_W:1];
            mem_rd_en = 1'b1;
            if ((hi_v - lo_v) > ADDR_W'(1)) begin
               mem_rd_addr = sum_v[ADDR_W:1];
            end else begin
               mem_rd_addr = lo_v;
               state_in    = ST_RD_LO;
            end
         end
         ST_RD_LO: begin
            xl_in       = mem_rd_data.x;
            yl_in       = mem_rd_data.y;
            mem_rd_en   = 1'b1;
            mem_rd_addr = hi_ff;
            state_in    = ST_RD_HI;
         end
         ST_RD_HI: begin
            // interval length and offsets, 33-bit signed
            len_in   = (DATA_W+1)'(mem_rd_data.x) - (DATA_W+1)'(xl_ff);
            dx_in    = (DATA_W+1)'(qx_ff) - (DATA_W+1)'(xl_ff);
            dy_in    = (DATA_W+1)'(mem_rd_data.y) - (DATA_W+1)'(yl_ff);
            state_in = ST_MAG;
         end
         ST_MAG: begin
            // zero-length interval returns the left y
            if (len_ff == '0) begin
               res_in   = yl_ff;
               flag_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               mlen_in  = len_ff[DATA_W] ? DATA_W'(-len_ff) : DATA_W'(len_ff);
               mdx_in   = dx_ff[DATA_W] ? DATA_W'(-dx_ff) : DATA_W'(dx_ff);
               mdy_in   = dy_ff[DATA_W] ? DATA_W'(-dy_ff) : DATA_W'(dy_ff);
               neg_in   = dy_ff[DATA_W] ^ dx_ff[DATA_W] ^ len_ff[DATA_W];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 64'(mdy_ff) * 64'(mdx_ff);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WT;
         end
         ST_DIV_WT: begin
            if (div_done) begin
               state_in = ST_OFFS;
            end
         end
         ST_OFFS: begin
            // signed offset from the clamped quotient
            if (neg_ff) begin
               off_in = -$signed({1'b0, div_quotient});
            end else begin
               off_in = $signed({1'b0, div_quotient});
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // left y plus offset, saturated to 32 bits
            total_v = (OFF_W+1)'(yl_ff) + (OFF_W+1)'(off_ff);
            if (total_v > (OFF_W+1)'(64'sd2147483647)) begin
               res_in = DATA_W'(32'h7fffffff);
            end else if (total_v < -(OFF_W+1)'(64'sd2147483648)) begin
               res_in = DATA_W'(32'h80000000);
            end else begin
               res_in = DATA_W'(total_v);
            end
            flag_in  = 1'b0;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      qx_ff        <= qx_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      xl_ff        <= xl_in;
      yl_ff        <= yl_in;
      len_ff       <= len_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      mlen_ff      <= mlen_in;
      mdx_ff       <= mdx_in;
      mdy_ff       <= mdy_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      off_ff       <= off_in;
      res_ff       <= res_in;
      flag_ff      <= flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_interp_value  = rsp_value_ff;
   assign rsp_zero_interval = rsp_flag_ff;

endmodule
